[rtl/trsc_pkg.sv]
// Shared types, constants and tables of the two-axis ramp scaler.
`default_nettype none

package trsc_pkg;

  // Field and datapath widths that the register map and the ports fix.
  localparam int BASE_W   = 23;  // widest ramp register
  localparam int NUM_RAMP = 8;
  localparam int IDX_W    = 3;
  localparam int WORD_W   = 32;
  localparam int DIST_W   = 33;  // |a - b| of two int32 values
  localparam int VAL_W    = 24;  // scaled value never exceeds 2^23
  localparam int CODE_W   = 4;
  localparam int DIGIT_W  = 4;   // ratio digit consumed per multiplier step

  localparam logic [IDX_W-1:0] LAST_RAMP = IDX_W'(NUM_RAMP - 1);

  // Register codes written on the output channel.
  localparam logic [CODE_W-1:0] CODE_VSTART   = 4'd0;
  localparam logic [CODE_W-1:0] CODE_A1       = 4'd1;
  localparam logic [CODE_W-1:0] CODE_V1       = 4'd2;
  localparam logic [CODE_W-1:0] CODE_AMAX     = 4'd3;
  localparam logic [CODE_W-1:0] CODE_VMAX     = 4'd4;
  localparam logic [CODE_W-1:0] CODE_DMAX     = 4'd5;
  localparam logic [CODE_W-1:0] CODE_D1       = 4'd6;
  localparam logic [CODE_W-1:0] CODE_VSTOP    = 4'd7;
  localparam logic [CODE_W-1:0] CODE_RAMPMODE = 4'd8;
  localparam logic [CODE_W-1:0] CODE_XTARGET  = 4'd9;

  localparam int RAMP_WIDTH [NUM_RAMP] = '{18, 16, 20, 16, 23, 16, 16, 18};

  localparam logic [BASE_W-1:0] RAMP_RESET [NUM_RAMP] = '{
    23'd0, 23'd1000, 23'd50000, 23'd500, 23'd200000, 23'd700, 23'd1400, 23'd10
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_LONG,
    ST_DIV,
    ST_DECIDE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_RMODE0,
    ST_RMODE1,
    ST_TGT0,
    ST_TGT1
  } trsc_state_e;

  // Mask of the bits that one ramp register really has.
  function automatic logic [BASE_W-1:0] ramp_mask(logic [IDX_W-1:0] idx);
    logic [BASE_W:0] m;
    m = ({{BASE_W{1'b0}}, 1'b1} << RAMP_WIDTH[idx]) - {{BASE_W{1'b0}}, 1'b1};
    return m[BASE_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/trsc_div.sv]
// Bit-serial restoring divider that forms one axis ratio, one quotient bit per cycle.
`default_nettype none

module trsc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [trsc_pkg::DIST_W-1:0] num_i,
  input  logic [trsc_pkg::DIST_W-1:0] den_i,
  output logic                        busy_o,
  output logic [FRAC_BITS:0]          quot_o
);
  import trsc_pkg::*;

  localparam int RW = FRAC_BITS + 1;
  localparam int CW = $clog2(RW);

  logic              busy_q;
  logic [CW-1:0]     cnt_q;
  logic [DIST_W-1:0] rem_q, den_q;
  logic [RW-1:0]     quot_q;

  logic [DIST_W:0]   trial, trial_sub;
  logic              take;
  logic [DIST_W-1:0] rem_d;

  // The numerator never exceeds the divisor, so the first step compares without doubling.
  always_comb begin
    trial     = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    take      = trial >= {1'b0, den_q};
    trial_sub = trial - {1'b0, den_q};
    rem_d     = take ? trial_sub[DIST_W-1:0] : trial[DIST_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(RW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[RW-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[rtl/trsc_mul.sv]
// Digit-serial ratio multiplier with round-half-up and floor for one ramp value.
`default_nettype none

module trsc_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [trsc_pkg::BASE_W-1:0] base_i,
  input  logic [FRAC_BITS:0]          ratio_i,
  input  logic                        floor_one_i,
  output logic                        busy_o,
  output logic [trsc_pkg::WORD_W-1:0] value_o
);
  import trsc_pkg::*;

  localparam int RW  = FRAC_BITS + 1;
  localparam int ND  = (RW + DIGIT_W - 1) / DIGIT_W;
  localparam int SHW = ND * DIGIT_W;
  localparam int AW  = BASE_W + RW;
  localparam int CW  = $clog2(ND);
  localparam logic [AW:0] HALF = {{AW{1'b0}}, 1'b1} << (FRAC_BITS - 1);

  logic              busy_q;
  logic [CW-1:0]     cnt_q;
  logic [SHW-1:0]    sh_q;
  logic [AW-1:0]     acc_q;
  logic [BASE_W-1:0] base_q;
  logic              floor_q;

  logic [DIGIT_W-1:0]        digit;
  logic [BASE_W+DIGIT_W-1:0] pp;
  logic [AW-1:0]             acc_d;
  logic [AW:0]               rsum;
  logic [VAL_W-1:0]          rval, fval;

  // Consume the ratio most significant digit first.
  always_comb begin
    digit = sh_q[SHW-1 -: DIGIT_W];
    pp    = base_q * digit;
    acc_d = {acc_q[AW-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + AW'(pp);
  end

  always_comb begin
    rsum = {1'b0, acc_q} + HALF;
    rval = rsum[FRAC_BITS +: VAL_W];
    fval = (floor_q && (rval == '0)) ? VAL_W'(1) : rval;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(ND - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= '0;
      sh_q    <= SHW'(ratio_i);
      base_q  <= base_i;
      floor_q <= floor_one_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      sh_q  <= {sh_q[SHW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign busy_o  = busy_q;
  assign value_o = WORD_W'(fval);

endmodule

`default_nettype wire

[rtl/two_axis_ramp_scaler_core.sv]
// Top level of the two-axis ramp scaler: request sequencer, ratio state and output beat.
`default_nettype none

// Each input beat is a two-axis move request. The core takes the distance of each axis,
// divides it by the longer one into a ratio with SCALE_FRACTION_BITS fraction bits, and
// emits a stream of register writes (axis, code, value, last) on the output channel. In
// scaled mode an axis gets all eight ramp values rewritten, scaled by its ratio, when the
// ratio moved beyond the tolerance from the stored one; then ramp mode and both targets
// follow. In rate-matched mode only the two scaled cruise velocities and the targets go
// out. The core works on one request at a time: in_stall_o is high from the accepting
// edge until the last beat of the request sits in the output register. A request goes
// from the accepting state through the distance states, the bit-serial dividers and their
// done check (skipped when both distances are zero) and a decision state, then through the
// 4-bit digit-serial multiplier for each scaled value and a load for each constant beat;
// every beat load waits while a stalled beat still sits in the output register. The ramp
// registers are written through cfg_we_i / cfg_index_i / cfg_data_i; the user must write
// them only while the core is idle, and the core itself does not enforce this. Bits above
// a register's width are dropped.
module two_axis_ramp_scaler_core #(
  parameter int SCALE_FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_we_i,
  input  logic [trsc_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [trsc_pkg::BASE_W-1:0] cfg_data_i,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [31:0]                 target_a_i,
  input  logic [31:0]                 target_b_i,
  input  logic [31:0]                 start_a_i,
  input  logic [31:0]                 start_b_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        axis_o,
  output logic [trsc_pkg::CODE_W-1:0] param_code_o,
  output logic [31:0]                 write_value_o,
  output logic                        last_o
);
  import trsc_pkg::*;

  localparam int RW    = SCALE_FRACTION_BITS + 1;
  localparam int TOL_I = (2 * (2 ** SCALE_FRACTION_BITS)) / 1000;
  localparam logic [RW-1:0] TOL = RW'(TOL_I);
  localparam logic [RW-1:0] ONE = {1'b1, {SCALE_FRACTION_BITS{1'b0}}};

  // Distance of one axis as a 33-bit magnitude; both differences run side by side.
  function automatic logic [DIST_W-1:0] abs_dist(logic [31:0] t, logic [31:0] s);
    logic signed [DIST_W-1:0] te, se, dp, dn;
    te = signed'({t[31], t});
    se = signed'({s[31], s});
    dp = te - se;
    dn = se - te;
    return (te >= se) ? DIST_W'(dp) : DIST_W'(dn);
  endfunction

  trsc_state_e state_q, state_d;

  // Ramp registers and per-axis scale state.
  logic [BASE_W-1:0] ramp_q [NUM_RAMP];
  logic [RW-1:0]     applied_q [2];
  logic [1:0]        unknown_q;

  // Request payload.
  logic        rate_q;
  logic [31:0] tgt_a_q, tgt_b_q, st_a_q, st_b_q;

  logic [DIST_W-1:0] dist_q [2];
  logic [DIST_W-1:0] longest;
  logic              zero_q;
  logic              rw_b_q;
  logic [1:0]        rw_now;
  logic              ax_q, ax_d;
  logic [IDX_W-1:0]  k_q, k_d;

  // Output beat register.
  logic              out_valid_q;
  logic              out_axis_q;
  logic [CODE_W-1:0] out_code_q;
  logic [31:0]       out_value_q;
  logic              out_last_q;

  logic              in_accept, slot_free;
  logic              div_start, mul_start, decide;
  logic [1:0]        div_busy;
  logic [RW-1:0]     ratio [2];
  logic              mul_busy;
  logic [WORD_W-1:0] mul_value;
  logic              ld, ld_axis, ld_last;
  logic [CODE_W-1:0] ld_code;
  logic [31:0]       ld_value;
  logic [RW-1:0]     sdiff [2];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign longest    = (dist_q[0] > dist_q[1]) ? dist_q[0] : dist_q[1];

  trsc_div #(.FRAC_BITS(SCALE_FRACTION_BITS)) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dist_q[0]),
    .den_i   (longest),
    .busy_o  (div_busy[0]),
    .quot_o  (ratio[0])
  );

  trsc_div #(.FRAC_BITS(SCALE_FRACTION_BITS)) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dist_q[1]),
    .den_i   (longest),
    .busy_o  (div_busy[1]),
    .quot_o  (ratio[1])
  );

  // One multiplier serves every scaled value; vstart alone may scale down to zero.
  trsc_mul #(.FRAC_BITS(SCALE_FRACTION_BITS)) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (mul_start),
    .base_i      (ramp_q[k_q]),
    .ratio_i     (ax_q ? ratio[1] : ratio[0]),
    .floor_one_i ({1'b0, k_q} != CODE_VSTART),
    .busy_o      (mul_busy),
    .value_o     (mul_value)
  );

  // Rewrite an axis when its scale is unknown or the ratio drifted past the tolerance.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sdiff[i]  = (ratio[i] > applied_q[i]) ? ratio[i] - applied_q[i]
                                            : applied_q[i] - ratio[i];
      rw_now[i] = unknown_q[i] || (sdiff[i] > TOL);
    end
  end

  // Sequencer: next state, unit starts and output beat loads.
  always_comb begin
    state_d   = state_q;
    ax_d      = ax_q;
    k_d       = k_q;
    div_start = 1'b0;
    mul_start = 1'b0;
    decide    = 1'b0;
    ld        = 1'b0;
    ld_axis   = 1'b0;
    ld_code   = CODE_RAMPMODE;
    ld_value  = '0;
    ld_last   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIST;
        end
      end
      ST_DIST: begin
        state_d = ST_LONG;
      end
      ST_LONG: begin
        if (longest == '0) begin
          state_d = ST_DECIDE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_busy == 2'b00) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        decide = 1'b1;
        if (zero_q) begin
          state_d = rate_q ? ST_TGT0 : ST_RMODE0;
        end else if (rate_q) begin
          ax_d    = 1'b0;
          k_d     = CODE_VMAX[IDX_W-1:0];
          state_d = ST_MUL_GO;
        end else if (rw_now[0]) begin
          ax_d    = 1'b0;
          k_d     = '0;
          state_d = ST_MUL_GO;
        end else if (rw_now[1]) begin
          ax_d    = 1'b1;
          k_d     = '0;
          state_d = ST_MUL_GO;
        end else begin
          state_d = ST_RMODE0;
        end
      end
      ST_MUL_GO: begin
        mul_start = 1'b1;
        state_d   = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (!mul_busy && slot_free) begin
          ld       = 1'b1;
          ld_axis  = ax_q;
          ld_code  = {1'b0, k_q};
          ld_value = mul_value;
          if (rate_q) begin
            if (!ax_q) begin
              ax_d    = 1'b1;
              state_d = ST_MUL_GO;
            end else begin
              state_d = ST_TGT0;
            end
          end else if (k_q != LAST_RAMP) begin
            k_d     = k_q + IDX_W'(1);
            state_d = ST_MUL_GO;
          end else if (!ax_q && rw_b_q) begin
            ax_d    = 1'b1;
            k_d     = '0;
            state_d = ST_MUL_GO;
          end else begin
            state_d = ST_RMODE0;
          end
        end
      end
      ST_RMODE0: begin
        if (slot_free) begin
          ld      = 1'b1;
          state_d = ST_RMODE1;
        end
      end
      ST_RMODE1: begin
        if (slot_free) begin
          ld      = 1'b1;
          ld_axis = 1'b1;
          state_d = ST_TGT0;
        end
      end
      ST_TGT0: begin
        if (slot_free) begin
          ld       = 1'b1;
          ld_code  = CODE_XTARGET;
          ld_value = tgt_a_q;
          state_d  = ST_TGT1;
        end
      end
      ST_TGT1: begin
        if (slot_free) begin
          ld       = 1'b1;
          ld_axis  = 1'b1;
          ld_code  = CODE_XTARGET;
          ld_value = tgt_b_q;
          ld_last  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ax_q    <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      k_q     <= k_d;
    end
  end

  // Ramp registers: drop the bits above each register's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_RAMP; i++) begin
        ramp_q[i] <= RAMP_RESET[i];
      end
    end else if (cfg_we_i) begin
      ramp_q[cfg_index_i] <= cfg_data_i & ramp_mask(cfg_index_i);
    end
  end

  // Scale state: update only on a nonzero move; the axis-b rewrite flag is reloaded at every decision.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      applied_q[0] <= '0;
      applied_q[1] <= '0;
      unknown_q    <= 2'b00;
      rw_b_q       <= 1'b0;
    end else if (decide) begin
      rw_b_q <= !(zero_q || rate_q) && rw_now[1];
      if (!zero_q) begin
        if (rate_q) begin
          unknown_q <= 2'b11;
        end else begin
          for (int i = 0; i < 2; i++) begin
            if (rw_now[i]) begin
              applied_q[i] <= ratio[i];
              unknown_q[i] <= 1'b0;
            end
          end
        end
      end
    end
  end

  // Request payload and distances.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rate_q  <= req_type_i;
      tgt_a_q <= target_a_i;
      tgt_b_q <= target_b_i;
      st_a_q  <= start_a_i;
      st_b_q  <= start_b_i;
    end
    if (state_q == ST_DIST) begin
      dist_q[0] <= abs_dist(tgt_a_q, st_a_q);
      dist_q[1] <= abs_dist(tgt_b_q, st_b_q);
    end
    if (state_q == ST_LONG) begin
      zero_q <= (longest == '0);
    end
  end

  // Output beat: load when the slot is free, clear once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_axis_q  <= ld_axis;
      out_code_q  <= ld_code;
      out_value_q <= ld_value;
      out_last_q  <= ld_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign axis_o        = out_axis_q;
  assign param_code_o  = out_code_q;
  assign write_value_o = out_value_q;
  assign last_o        = out_last_q;

  // The longer axis always divides to exactly one, and no ratio exceeds one.
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && !zero_q) |->
      ((ratio[0] == ONE || ratio[1] == ONE) && ratio[0] <= ONE && ratio[1] <= ONE))
    else $error("ratio out of range after division");

  // Only the second target write closes a request.
  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (param_code_o == CODE_XTARGET && axis_o))
    else $error("last set on a beat other than the second target");

  // A new beat never overwrites one that the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |-> !(out_valid_q && out_stall_i))
    else $error("output beat overwritten while stalled");

  // The request is finished once its last beat is loaded.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && ld_last) |=> (state_q == ST_IDLE))
    else $error("sequencer not idle after last beat");

endmodule

`default_nettype wire

[sim/two_axis_ramp_scaler_core_test.sv]
// Self-checking testbench of the two-axis ramp scaler core: directed and random moves.
`timescale 1ns / 1ps

module two_axis_ramp_scaler_core_test;

  localparam int F             = 16;
  localparam int HALF_PERIOD   = 6;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_SHOWN     = 10;
  localparam int PHASE_SETTLE  = 20;
  localparam int FINAL_SETTLE  = 200;
  localparam int LONG_HOLD     = 400;
  localparam int NUM_RAMP      = trsc_pkg::NUM_RAMP;
  localparam int BW            = trsc_pkg::BASE_W;
  localparam int IW            = trsc_pkg::IDX_W;
  localparam int CW            = trsc_pkg::CODE_W;
  // Ratio drift that still counts as the same scale.
  localparam int SCALE_TOL     = (2 << F) / 1000;

  localparam int RAMP_BITS [NUM_RAMP] = '{18, 16, 20, 16, 23, 16, 16, 18};
  localparam logic [BW-1:0] RAMP_DEFAULT [NUM_RAMP] = '{
    23'd0, 23'd1000, 23'd50000, 23'd500, 23'd200000, 23'd700, 23'd1400, 23'd10
  };

  typedef struct packed {
    logic        req_type;
    logic [31:0] target_a;
    logic [31:0] target_b;
    logic [31:0] start_a;
    logic [31:0] start_b;
  } move_t;

  typedef struct packed {
    logic          axis;
    logic [CW-1:0] code;
    logic [31:0]   value;
    logic          last;
  } reg_write_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          cfg_we_i    = 1'b0;
  logic [IW-1:0] cfg_index_i = '0;
  logic [BW-1:0] cfg_data_i  = '0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  logic          req_type_i  = 1'b0;
  logic [31:0]   target_a_i  = '0;
  logic [31:0]   target_b_i  = '0;
  logic [31:0]   start_a_i   = '0;
  logic [31:0]   start_b_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic          axis_o;
  logic [CW-1:0] param_code_o;
  logic [31:0]   write_value_o;
  logic          last_o;

  two_axis_ramp_scaler_core #(
    .SCALE_FRACTION_BITS(F)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .target_a_i   (target_a_i),
    .target_b_i   (target_b_i),
    .start_a_i    (start_a_i),
    .start_b_i    (start_b_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .axis_o       (axis_o),
    .param_code_o (param_code_o),
    .write_value_o(write_value_o),
    .last_o       (last_o)
  );

  // Predictor copy of the ramp registers and the per-axis scale state.
  logic [BW-1:0] ramp_base    [NUM_RAMP];
  logic [BW-1:0] ramp_setting [NUM_RAMP];
  logic [F:0]    axis_scale   [2];
  logic          scale_stale  [2];

  move_t      move_queue[$];
  reg_write_t predicted_writes[$];
  move_t      offered_move;
  reg_write_t got_write;
  reg_write_t want_write;

  int errors        = 0;
  int cycle_count   = 0;
  int in_gap_max    = 8;
  int out_gap_max   = 8;
  int in_gap_left   = 0;
  int out_gap_left  = 0;
  int out_hold_left = 0;
  int last_da       = 0;
  int last_db       = 0;
  bit in_taken      = 1'b0;
  bit out_taken     = 1'b0;

  initial begin
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // |target - start| of two int32 positions, without overflow.
  function automatic logic [32:0] axis_distance(logic [31:0] tgt, logic [31:0] src);
    logic signed [33:0] d;
    d = $signed({{2{tgt[31]}}, tgt}) - $signed({{2{src[31]}}, src});
    return (d < 0) ? 33'(-d) : 33'(d);
  endfunction

  // Round half up, then floor at 1 unless zero may pass.
  function automatic logic [31:0] scaled_value(logic [BW-1:0] base, logic [F:0] ratio,
                                               bit zero_ok);
    logic [63:0] prod;
    prod = (64'(base) * 64'(ratio) + (64'd1 << (F - 1))) >> F;
    if (!zero_ok && prod == 64'd0) prod = 64'd1;
    return prod[31:0];
  endfunction

  task automatic push_write(logic axis, logic [CW-1:0] code, logic [31:0] value);
    reg_write_t w;
    w.axis  = axis;
    w.code  = code;
    w.value = value;
    w.last  = 1'b0;
    predicted_writes.push_back(w);
  endtask

  // Work out the register writes that one accepted move causes.
  task automatic predict_move_writes(input move_t m);
    logic [32:0] axis_dist [2];
    logic [32:0] longest;
    logic [48:0] quot;
    logic [F:0]  ratio [2];
    logic [F:0]  drift;
    reg_write_t  tail_w;
    axis_dist[0] = axis_distance(m.target_a, m.start_a);
    axis_dist[1] = axis_distance(m.target_b, m.start_b);
    longest = (axis_dist[0] > axis_dist[1]) ? axis_dist[0] : axis_dist[1];
    for (int ax = 0; ax < 2; ax++) begin
      if (longest != 0) begin
        quot = {axis_dist[ax], {F{1'b0}}} / {{F{1'b0}}, longest};
        ratio[ax] = quot[F:0];
      end else begin
        ratio[ax] = '0;
      end
    end
    if (!m.req_type) begin
      if (longest != 0) begin
        for (int ax = 0; ax < 2; ax++) begin
          drift = (ratio[ax] > axis_scale[ax]) ? ratio[ax] - axis_scale[ax]
                                               : axis_scale[ax] - ratio[ax];
          if (scale_stale[ax] || drift > SCALE_TOL) begin
            for (int k = 0; k < NUM_RAMP; k++) begin
              push_write(ax[0], trsc_pkg::CODE_VSTART + k[CW-1:0],
                         scaled_value(ramp_base[k], ratio[ax], k == 0));
            end
            axis_scale[ax]  = ratio[ax];
            scale_stale[ax] = 1'b0;
          end
        end
      end
      push_write(1'b0, trsc_pkg::CODE_RAMPMODE, 32'd0);
      push_write(1'b1, trsc_pkg::CODE_RAMPMODE, 32'd0);
    end else if (longest != 0) begin
      for (int ax = 0; ax < 2; ax++) begin
        push_write(ax[0], trsc_pkg::CODE_VMAX, scaled_value(ramp_base[4], ratio[ax], 1'b0));
      end
      scale_stale[0] = 1'b1;
      scale_stale[1] = 1'b1;
    end
    push_write(1'b0, trsc_pkg::CODE_XTARGET, m.target_a);
    push_write(1'b1, trsc_pkg::CODE_XTARGET, m.target_b);
    tail_w      = predicted_writes.pop_back();
    tail_w.last = 1'b1;
    predicted_writes.push_back(tail_w);
  endtask

  task automatic queue_move(logic rt, logic [31:0] ta, logic [31:0] tb,
                            logic [31:0] sa, logic [31:0] sb);
    move_t m;
    m.req_type = rt;
    m.target_a = ta;
    m.target_b = tb;
    m.start_a  = sa;
    m.start_b  = sb;
    move_queue.push_back(m);
  endtask

  // Mix of wild moves, short moves, near repeats that probe the tolerance, and single-axis and zero moves.
  function automatic move_t random_move();
    move_t m;
    int    kind;
    int    span;
    int    da;
    int    db;
    kind = $urandom_range(0, 9);
    case ($urandom_range(0, 2))
      0:       span = 15;
      1:       span = 1000;
      default: span = 70000;
    endcase
    m.req_type = ($urandom_range(0, 3) == 0);
    m.start_a  = $urandom;
    m.start_b  = $urandom;
    da = int'($urandom_range(0, 2 * span)) - span;
    db = int'($urandom_range(0, 2 * span)) - span;
    case (kind)
      0, 1: begin
        da = int'($urandom);
        db = int'($urandom);
      end
      2, 3, 4, 5: ;
      6, 7: begin
        da = last_da + int'($urandom_range(0, 6)) - 3;
        db = last_db + int'($urandom_range(0, 6)) - 3;
      end
      8: begin
        if ($urandom_range(0, 1) == 0) da = 0;
        else db = 0;
      end
      default: begin
        da = 0;
        db = 0;
      end
    endcase
    m.target_a = m.start_a + da;
    m.target_b = m.start_b + db;
    last_da    = da;
    last_db    = db;
    return m;
  endfunction

  // Write every ramp register from ramp_setting; only call while the core is idle.
  task automatic load_ramp_setting();
    logic [63:0] full_mask;
    for (int i = 0; i < NUM_RAMP; i++) begin
      @(negedge clk_i);
      full_mask    = (64'd1 << RAMP_BITS[i]) - 64'd1;
      cfg_we_i     = 1'b1;
      cfg_index_i  = i[IW-1:0];
      cfg_data_i   = ramp_setting[i];
      ramp_base[i] = ramp_setting[i] & full_mask[BW-1:0];
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Hold until every queued move went in and every predicted write came out.
  task automatic wait_drained(input int settle);
    while (move_queue.size() != 0 || in_valid_i || predicted_writes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (settle) @(posedge clk_i);
  endtask

  // Input driver: hold an offered beat until taken, then idle or present the next move.
  always @(negedge clk_i) begin
    if (!(in_valid_i && !in_taken)) begin
      in_taken = 1'b0;
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid_i = 1'b0;
      end else if (move_queue.size() > 0) begin
        offered_move = move_queue.pop_front();
        req_type_i   = offered_move.req_type;
        target_a_i   = offered_move.target_a;
        target_b_i   = offered_move.target_b;
        start_a_i    = offered_move.start_a;
        start_b_i    = offered_move.start_b;
        in_valid_i   = 1'b1;
        in_gap_left  = $urandom_range(0, in_gap_max);
      end else begin
        in_valid_i = 1'b0;
      end
    end
  end

  // Output receiver: draw a stall per taken beat; a long hold overrides everything.
  always @(negedge clk_i) begin
    if (out_taken) begin
      out_taken    = 1'b0;
      out_gap_left = $urandom_range(0, out_gap_max);
    end
    if (out_hold_left > 0) begin
      out_hold_left--;
      out_stall_i = 1'b1;
    end else if (out_gap_left > 0) begin
      out_gap_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Monitor: predict on each accepted move, check each accepted write beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_move_writes(offered_move);
        in_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        out_taken       = 1'b1;
        got_write.axis  = axis_o;
        got_write.code  = param_code_o;
        got_write.value = write_value_o;
        got_write.last  = last_o;
        if (predicted_writes.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("unexpected write beat: axis %0d code %0d value %h last %0d",
                     got_write.axis, got_write.code, got_write.value, got_write.last);
          end
        end else begin
          want_write = predicted_writes.pop_front();
          if (got_write.axis !== want_write.axis || got_write.code !== want_write.code ||
              got_write.value !== want_write.value || got_write.last !== want_write.last)
          begin
            errors++;
            if (errors <= MAX_SHOWN) begin
              $display("write mismatch: expected axis %0d code %0d value %h last %0d,",
                       want_write.axis, want_write.code, want_write.value, want_write.last,
                       " got axis %0d code %0d value %h last %0d",
                       got_write.axis, got_write.code, got_write.value, got_write.last);
            end
          end
        end
      end
    end
  end

  int phase_items [5] = '{90, 70, 90, 70, 90};

  initial begin
    for (int i = 0; i < NUM_RAMP; i++) ramp_base[i] = RAMP_DEFAULT[i];
    axis_scale[0]  = '0;
    axis_scale[1]  = '0;
    scale_stale[0] = 1'b0;
    scale_stale[1] = 1'b0;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed moves at the reset register values.
    queue_move(1'b0, 32'd100, 32'hFFFF_FFFB, 32'd100, 32'hFFFF_FFFB);  // no motion
    queue_move(1'b1, 32'd0, 32'd0, 32'd0, 32'd0);                      // no motion, matched
    queue_move(1'b0, 32'd1000, 32'd0, 32'd0, 32'd0);                   // axis a only
    queue_move(1'b0, 32'd1000, 32'd0, 32'd0, 32'd0);                   // same ratio again
    queue_move(1'b0, 32'd0, 32'hFFFF_FC18, 32'd0, 32'd0);              // axis b only
    queue_move(1'b0, 32'd500, 32'd500, 32'd0, 32'd0);                  // diagonal
    queue_move(1'b0, 32'd1000, 32'd999, 32'd0, 32'd0);                 // inside tolerance
    queue_move(1'b0, 32'd1000, 32'd997, 32'd0, 32'd0);                 // just past it
    queue_move(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_move(1'b0, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000, 32'd0);      // ratio rounds to zero
    queue_move(1'b1, 32'd3, 32'd7, 32'd0, 32'd0);                      // scales go unknown
    queue_move(1'b0, 32'd3, 32'd7, 32'd0, 32'd0);                      // forced rewrite
    queue_move(1'b0, 32'd3, 32'd7, 32'd0, 32'd0);
    queue_move(1'b1, 32'd42, 32'd42, 32'd42, 32'd42);                  // targets only
    queue_move(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    queue_move(1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    queue_move(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_move(1'b0, 32'd12345, 32'hFFFE_F6CE, 32'hFFFF_FFFF, 32'd2);
    queue_move(1'b1, 32'd2, 32'd1, 32'd0, 32'd0);                      // half ratio
    wait_drained(PHASE_SETTLE);

    for (int p = 0; p < 5; p++) begin
      for (int i = 0; i < NUM_RAMP; i++) begin
        case (p)
          0:       ramp_setting[i] = {BW{1'b1}};
          1:       ramp_setting[i] = '0;
          2:       ramp_setting[i] = BW'($urandom);
          3:       ramp_setting[i] = BW'($urandom_range(0, 15));
          default: ramp_setting[i] = RAMP_DEFAULT[i];
        endcase
      end
      load_ramp_setting();
      case (p)
        1: begin
          in_gap_max  = 0;
          out_gap_max = 0;
        end
        3: begin
          in_gap_max  = 3;
          out_gap_max = 8;
        end
        default: begin
          in_gap_max  = 8;
          out_gap_max = 8;
        end
      endcase
      for (int n = 0; n < phase_items[p]; n++) move_queue.push_back(random_move());
      if (p == 0 || p == 3) begin
        // Block the output long enough for the input side to back up.
        @(posedge clk_i);
        out_hold_left = LONG_HOLD;
      end
      wait_drained((p == 4) ? FINAL_SETTLE : PHASE_SETTLE);
    end

    errors += predicted_writes.size();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
